[rtl/twdp_pkg.sv]
package twdp_pkg;

  localparam int unsigned MAX_LANES = 8;
  localparam int unsigned ACT_W     = 8;
  localparam int unsigned CODE_W    = 2;
  localparam int unsigned ACTS_W    = MAX_LANES * ACT_W;
  localparam int unsigned CODES_W   = MAX_LANES * CODE_W;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned PROD_W    = ACT_W + 2;
  localparam int unsigned SUM_W     = PROD_W + $clog2(MAX_LANES);
  localparam int unsigned ACC_W     = 32;

  localparam logic [CODE_W-1:0] CODE_NEG  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ZERO = 2'd1;
  localparam logic [CODE_W-1:0] CODE_POS  = 2'd2;
  localparam logic [CODE_W-1:0] CODE_DBL  = 2'd3;

  typedef struct packed {
    logic advance;
    logic last;
  } acc_ctrl_t;

  function automatic logic signed [PROD_W-1:0] lane_product(
    input logic signed [ACT_W-1:0] act,
    input logic [CODE_W-1:0]       code
  );
    logic signed [PROD_W-1:0] a;
    a = PROD_W'(act);
    case (code)
      CODE_NEG:  lane_product = -a;
      CODE_ZERO: lane_product = '0;
      CODE_POS:  lane_product = a;
      CODE_DBL:  lane_product = a <<< 1;
      default:   lane_product = '0;
    endcase
  endfunction

endpackage

[rtl/ternary_weight_dot_product_top.sv]
// An accepted last word is registered at the input, then at the result.
// Throughput: one word per cycle unless stalled; input register feeds lane
// adder tree and single 32-bit accumulate, which writes the result register.
// A held result only stalls the input when the next word is also last.
// Reset (rst_ni low, asynchronous) clears the accumulator and all valid flags.
module ternary_weight_dot_product_top #(
  parameter int unsigned LANES = twdp_pkg::MAX_LANES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [twdp_pkg::ACTS_W-1:0]         activations_i,
  input  logic [twdp_pkg::CODES_W-1:0]        weight_codes_i,
  input  logic [twdp_pkg::COUNT_W-1:0]        lanes_valid_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [twdp_pkg::ACC_W-1:0]   dot_sum_o
);
  import twdp_pkg::*;

  logic                  s1_valid_q;
  logic                  s1_valid_d;
  logic [ACTS_W-1:0]     acts_q;
  logic [CODES_W-1:0]    codes_q;
  logic [COUNT_W-1:0]    count_q;
  logic                  last_q;
  logic                  accept;
  logic signed [SUM_W-1:0] part_sum;
  acc_ctrl_t             ctrl;

  assign ctrl.last    = last_q;
  assign ctrl.advance = s1_valid_q && !(last_q && out_valid_o && out_stall_i);
  assign in_stall_o   = s1_valid_q && !ctrl.advance;
  assign accept       = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (ctrl.advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acts_q  <= activations_i;
      codes_q <= weight_codes_i;
      count_q <= lanes_valid_i;
      last_q  <= last_i;
    end
  end

  twdp_lane_sum #(
    .LANES(LANES)
  ) u_lane_sum (
    .activations_i (acts_q),
    .weight_codes_i(codes_q),
    .lanes_valid_i (count_q),
    .part_sum_o    (part_sum)
  );

  twdp_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .part_sum_i (part_sum),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .dot_sum_o  (dot_sum_o)
  );

endmodule

[rtl/twdp_lane_sum.sv]
module twdp_lane_sum #(
  parameter int unsigned LANES = twdp_pkg::MAX_LANES
) (
  input  logic [twdp_pkg::ACTS_W-1:0]         activations_i,
  input  logic [twdp_pkg::CODES_W-1:0]        weight_codes_i,
  input  logic [twdp_pkg::COUNT_W-1:0]        lanes_valid_i,
  output logic signed [twdp_pkg::SUM_W-1:0]   part_sum_o
);
  import twdp_pkg::*;

  logic signed [PROD_W-1:0] prod [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [ACT_W-1:0] act;
    logic [CODE_W-1:0]       code;
    assign act  = activations_i[ACT_W*i +: ACT_W];
    assign code = weight_codes_i[CODES_W-1-CODE_W*i -: CODE_W];
    assign prod[i] = (lanes_valid_i > COUNT_W'(i)) ? lane_product(act, code) : '0;
  end

  always_comb begin
    part_sum_o = '0;
    for (int i = 0; i < LANES; i++) begin
      part_sum_o = part_sum_o + SUM_W'(prod[i]);
    end
  end

endmodule

[rtl/twdp_acc.sv]
module twdp_acc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  twdp_pkg::acc_ctrl_t                 ctrl_i,
  input  logic signed [twdp_pkg::SUM_W-1:0]   part_sum_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [twdp_pkg::ACC_W-1:0]   dot_sum_o
);
  import twdp_pkg::*;

  logic [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0] acc_d;
  logic [ACC_W-1:0] sum;
  logic             emit;
  logic             valid_q;
  logic             valid_d;
  logic [ACC_W-1:0] dot_q;

  assign sum  = acc_q + ACC_W'(part_sum_i);
  assign emit = ctrl_i.advance && ctrl_i.last;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.advance) begin
      acc_d = ctrl_i.last ? '0 : sum;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (emit) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      dot_q <= sum;
    end
  end

  assign out_valid_o = valid_q;
  assign dot_sum_o   = $signed(dot_q);

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import twdp_pkg::*;

  typedef struct packed {
    logic [ACTS_W-1:0]       acts;
    logic [CODES_W-1:0]      codes;
    logic [COUNT_W-1:0]      count;
    logic                    last;
    logic                    fixed;
    logic signed [ACC_W-1:0] sum;
  } group_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ACTS_W-1:0]       activations_i;
  logic [CODES_W-1:0]      weight_codes_i;
  logic [COUNT_W-1:0]      lanes_valid_i;
  logic                    last_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [ACC_W-1:0] dot_sum_o;

  logic [ACC_W-1:0]        running_sum;
  logic signed [ACC_W-1:0] expected_sums[$];
  group_t                  directed_groups[$];
  int unsigned             send_idle_pct;
  int unsigned             stall_pct;
  int unsigned             mismatches;

  ternary_weight_dot_product_top #(
    .LANES(MAX_LANES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .activations_i (activations_i),
    .weight_codes_i(weight_codes_i),
    .lanes_valid_i (lanes_valid_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .dot_sum_o     (dot_sum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [ACC_W-1:0] accumulate_group(
    input logic [ACC_W-1:0]   acc,
    input logic [ACTS_W-1:0]  acts,
    input logic [CODES_W-1:0] codes,
    input logic [COUNT_W-1:0] count
  );
    int unsigned      used;
    logic signed [31:0] act;
    logic signed [31:0] weight;
    used = (count > MAX_LANES) ? MAX_LANES : count;
    for (int lane = 0; lane < used; lane++) begin
      act    = $signed(acts[ACT_W*lane +: ACT_W]);
      weight = int'(codes[CODES_W-CODE_W-CODE_W*lane +: CODE_W]) - 1;
      acc    = acc + 32'(act * weight);
    end
    return acc;
  endfunction

  task automatic add_row(
    input logic [ACTS_W-1:0]       acts,
    input logic [CODES_W-1:0]      codes,
    input logic [COUNT_W-1:0]      count,
    input logic                    last,
    input logic                    fixed,
    input logic signed [ACC_W-1:0] sum
  );
    group_t g;
    g.acts  = acts;
    g.codes = codes;
    g.count = count;
    g.last  = last;
    g.fixed = fixed;
    g.sum   = sum;
    directed_groups.push_back(g);
  endtask

  task automatic send_group(input group_t g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    activations_i  <= g.acts;
    weight_codes_i <= g.codes;
    lanes_valid_i  <= g.count;
    last_i         <= g.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    running_sum = accumulate_group(running_sum, g.acts, g.codes, g.count);
    if (g.last) begin
      expected_sums.push_back(g.fixed ? g.sum : $signed(running_sum));
      running_sum = '0;
    end
    @(negedge clk_i);
  endtask

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_sums.size() == 0) begin
        $error("dot_sum: no word expected, actual %0d", dot_sum_o);
        mismatches++;
      end else if (dot_sum_o !== expected_sums[0]) begin
        $error("dot_sum: expected %0d, actual %0d", expected_sums[0], dot_sum_o);
        mismatches++;
        void'(expected_sums.pop_front());
      end else begin
        void'(expected_sums.pop_front());
      end
    end
  end

  initial begin
    group_t      g;
    int unsigned sent;
    int unsigned len;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    activations_i  = '0;
    weight_codes_i = '0;
    lanes_valid_i  = '0;
    last_i         = 1'b0;
    running_sum    = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    mismatches     = 0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_row({8{8'h7f}}, {8{CODE_DBL}},  4'd8,  1'b1, 1'b1, 2032);
    add_row({8{8'h80}}, {8{CODE_DBL}},  4'd8,  1'b1, 1'b1, -2048);
    add_row({8{8'h80}}, {8{CODE_NEG}},  4'd8,  1'b1, 1'b1, 1024);
    add_row({8{8'h7f}}, {8{CODE_NEG}},  4'd8,  1'b1, 1'b1, -1016);
    add_row({8{8'hff}}, {8{CODE_ZERO}}, 4'd8,  1'b1, 1'b1, 0);
    add_row({8{8'h80}}, {8{CODE_POS}},  4'd8,  1'b1, 1'b1, -1024);
    add_row({8{8'h7f}}, {8{CODE_DBL}},  4'd0,  1'b1, 1'b1, 0);
    add_row({8{8'h01}}, {8{CODE_POS}},  4'd15, 1'b1, 1'b1, 8);
    add_row({8{8'h01}}, {8{CODE_POS}},  4'd9,  1'b1, 1'b1, 8);
    add_row({8{8'h01}}, {8{CODE_POS}},  4'd7,  1'b1, 1'b1, 7);
    add_row(64'h80, {CODE_POS, {7{CODE_DBL}}}, 4'd1, 1'b1, 1'b1, -128);
    add_row({8{8'h7f}}, {CODE_NEG, {7{CODE_DBL}}}, 4'd1, 1'b1, 1'b1, -127);
    add_row(64'h0102_0304_0506_0708,
            {CODE_NEG, CODE_ZERO, CODE_POS, CODE_DBL, CODE_DBL, CODE_POS, CODE_ZERO, CODE_NEG},
            4'd8, 1'b0, 1'b0, 0);
    add_row({8{8'h7f}}, {8{CODE_DBL}}, 4'd8, 1'b0, 1'b0, 0);
    add_row({8{8'h7f}}, {8{CODE_DBL}}, 4'd0, 1'b0, 1'b0, 0);
    add_row(64'hdead_beef_0bad_cafe, 16'h1b6c, 4'd5, 1'b1, 1'b0, 0);
    add_row(64'h8000_0000_0000_007f, {CODE_DBL, {6{CODE_ZERO}}, CODE_DBL},
            4'd8, 1'b1, 1'b0, 0);
    add_row(64'h55aa_33cc_0ff0_a55a, 16'he4e4, 4'd3, 1'b1, 1'b0, 0);
    add_row(64'hfedc_ba98_7654_3210, 16'h9c63, 4'd12, 1'b1, 1'b0, 0);
    add_row({8{8'h80}}, {8{CODE_DBL}}, 4'd8, 1'b0, 1'b0, 0);
    add_row({8{8'h80}}, {8{CODE_DBL}}, 4'd8, 1'b1, 1'b0, 0);

    foreach (directed_groups[i]) send_group(directed_groups[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 49;
        end
        default: begin
          send_idle_pct = 28;
          stall_pct     = 28;
        end
      endcase
      sent = 0;
      while (sent < 212) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          g.acts  = ($urandom_range(9) == 0) ? {8{8'h80}} : {$urandom, $urandom};
          g.codes = 16'($urandom);
          if ($urandom_range(7) == 0) begin
            g.count = 4'($urandom_range(15));
          end else if (k == len - 1) begin
            g.count = 4'($urandom_range(1, 8));
          end else begin
            g.count = 4'd8;
          end
          g.last  = (k == len - 1);
          g.fixed = 1'b0;
          g.sum   = '0;
          send_group(g);
          sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
